### design/g3c_pkg.sv
// Package for the graph three-colour criticality classifier.
// Holds the shared constants, the state and phase types and the request and status structs; no dependencies.
package g3c_pkg;

  localparam int unsigned MaxVertices     = 32;
  localparam int unsigned VertexCountW    = 6;
  localparam logic [5:0]  VertexCountRst  = 6'd14;
  localparam logic [1:0]  Uncoloured      = 2'd3;
  localparam logic [1:0]  NumColours      = 2'd3;

  // Result classes.
  localparam logic [1:0] ClassColourable = 2'd0;
  localparam logic [1:0] ClassNotCrit    = 2'd1;
  localparam logic [1:0] ClassCritEdge   = 2'd2;
  localparam logic [1:0] ClassTarget     = 2'd3;

  // Test phases of the classification.
  typedef enum logic [1:0] {
    PH_FULL,
    PH_VERTEX,
    PH_EDGE
  } phase_e;

  // Search engine states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DEG,
    S_SORT_OUTER,
    S_SORT_CMP,
    S_SRCH_FETCH,
    S_SRCH_TRY,
    S_SRCH_SCAN,
    S_DONE_OK,
    S_DONE_FAIL
  } search_e;

  // Controller states.
  typedef enum logic [2:0] {
    C_IDLE,
    C_RUN,
    C_WAIT,
    C_NEXT,
    C_EDGE_SCAN,
    C_REPORT
  } ctrl_e;

  // Request from the controller to the search engine.
  typedef struct packed {
    logic        start;
    logic [31:0] removed;
    logic        edge_valid;
    logic [4:0]  edge_a;
    logic [4:0]  edge_b;
  } search_req_t;

  // Status from the search engine.
  typedef struct packed {
    logic done;
    logic colourable;
  } search_rsp_t;

endpackage

### design/g3c_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module g3c_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/g3c_search.sv
// Backtracking 3-colour search engine: degree pass, insertion sort, search.
// Depends on g3c_pkg; reads the adjacency rows through a shared read port.
module g3c_search #(
  parameter int unsigned MaxV = g3c_pkg::MaxVertices
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [$clog2(MaxV):0]     n_i,
  input  g3c_pkg::search_req_t      req_i,
  output g3c_pkg::search_rsp_t      rsp_o,
  output logic [$clog2(MaxV)-1:0]   raddr_o,
  input  logic [31:0]               rdata_i
);
  import g3c_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxV);
  localparam int unsigned CntW = IdxW + 1;

  search_e state_q, state_d;

  // Degrees run up to MaxV, so they need one bit more than a vertex index.
  logic [CntW-1:0] deg_q [MaxV];
  logic [IdxW-1:0] order_q [MaxV];
  logic [1:0]      colour_q [MaxV];
  logic [1:0]      try_q [MaxV];

  logic [CntW-1:0] m_q, m_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic [IdxW-1:0] key_q, key_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [31:0]     nb_q, nb_d;
  logic [1:0]      c_q, c_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [31:0]     live;
  logic [31:0]     row_live;
  logic [CntW:0]   popcnt;

  // Per-element write controls.
  logic            deg_we;
  logic            ord_we;
  logic [IdxW-1:0] ord_wa;
  logic [IdxW-1:0] ord_wd;
  logic            col_we;
  logic [IdxW-1:0] col_wa;
  logic [1:0]      col_wd;
  logic            col_clr;
  logic            try_we;
  logic [IdxW-1:0] try_wa;
  logic [1:0]      try_wd;
  logic            try_we2;
  logic [IdxW-1:0] try_wa2;
  logic            list_we;

  // Neighbour scan: lowest set bit of the remaining mask.
  logic [IdxW-1:0] low_u;
  logic            blocked;
  logic            skip_u;

  always_comb begin
    live = '0;
    for (int k = 0; k < MaxV; k++) begin
      live[k] = (CntW'(k) < n_i);
    end
  end

  assign row_live = rdata_i & live;

  always_comb begin
    popcnt = '0;
    for (int k = 0; k < 32; k++) begin
      popcnt = popcnt + (CntW+1)'(row_live[k]);
    end
  end

  always_comb begin
    low_u = '0;
    for (int k = MaxV - 1; k >= 0; k--) begin
      if (nb_q[k]) begin
        low_u = IdxW'(k);
      end
    end
  end

  always_comb begin
    skip_u = req_i.removed[low_u] ||
             (req_i.edge_valid &&
              ((low_u == req_i.edge_a && cur_q == req_i.edge_b) ||
               (low_u == req_i.edge_b && cur_q == req_i.edge_a)));
    blocked = !skip_u && (colour_q[low_u] == c_q);
  end

  // Next state and datapath control.
  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    i_d     = i_q;
    j_d     = j_q;
    key_d   = key_q;
    pos_d   = pos_q;
    nb_d    = nb_q;
    c_d     = c_q;
    cur_d   = cur_q;
    raddr_o = i_q[IdxW-1:0];
    deg_we  = 1'b0;
    ord_we  = 1'b0;
    ord_wa  = '0;
    ord_wd  = '0;
    col_we  = 1'b0;
    col_wa  = '0;
    col_wd  = '0;
    col_clr = 1'b0;
    try_we  = 1'b0;
    try_wa  = '0;
    try_wd  = '0;
    try_we2 = 1'b0;
    try_wa2 = '0;
    list_we = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          i_d     = '0;
          m_d     = '0;
          raddr_o = '0;
          state_d = S_DEG;
        end
      end
      // One row a cycle: store degree and build the vertex list.
      S_DEG: begin
        raddr_o = IdxW'(i_q + 1'b1);
        deg_we  = 1'b1;
        if (!req_i.removed[i_q[IdxW-1:0]]) begin
          list_we = 1'b1;
          m_d     = m_q + 1'b1;
        end
        i_d = i_q + 1'b1;
        if (i_q + 1'b1 >= n_i) begin
          i_d     = CntW'(1);
          state_d = S_SORT_OUTER;
        end
      end
      S_SORT_OUTER: begin
        if (i_q >= m_q) begin
          col_clr = 1'b1;
          pos_d   = '0;
          try_we  = 1'b1;
          try_wa  = '0;
          try_wd  = 2'd0;
          state_d = S_SRCH_FETCH;
        end else begin
          key_d   = order_q[i_q[IdxW-1:0]];
          j_d     = i_q;
          state_d = S_SORT_CMP;
        end
      end
      // One shift step of the insertion sort a cycle.
      S_SORT_CMP: begin
        if (j_q != '0 && deg_q[order_q[IdxW'(j_q - 1'b1)]] < deg_q[key_q]) begin
          ord_we = 1'b1;
          ord_wa = j_q[IdxW-1:0];
          ord_wd = order_q[IdxW'(j_q - 1'b1)];
          j_d    = j_q - 1'b1;
        end else begin
          ord_we  = 1'b1;
          ord_wa  = j_q[IdxW-1:0];
          ord_wd  = key_q;
          i_d     = i_q + 1'b1;
          state_d = S_SORT_OUTER;
        end
      end
      S_SRCH_FETCH: begin
        if (pos_q >= m_q) begin
          state_d = S_DONE_OK;
        end else begin
          cur_d   = order_q[pos_q[IdxW-1:0]];
          c_d     = try_q[pos_q[IdxW-1:0]];
          raddr_o = order_q[pos_q[IdxW-1:0]];
          state_d = S_SRCH_TRY;
        end
      end
      // Start a colour attempt, or backtrack when colours run out.
      S_SRCH_TRY: begin
        raddr_o = cur_q;
        if (c_q >= NumColours) begin
          col_we = 1'b1;
          col_wa = cur_q;
          col_wd = Uncoloured;
          try_we = 1'b1;
          try_wa = pos_q[IdxW-1:0];
          try_wd = 2'd0;
          if (pos_q == '0) begin
            state_d = S_DONE_FAIL;
          end else begin
            pos_d   = pos_q - 1'b1;
            state_d = S_SRCH_FETCH;
          end
        end else begin
          nb_d    = row_live;
          state_d = S_SRCH_SCAN;
        end
      end
      // One neighbour checked a cycle.
      S_SRCH_SCAN: begin
        raddr_o = cur_q;
        if (nb_q == '0) begin
          col_we = 1'b1;
          col_wa = cur_q;
          col_wd = c_q;
          try_we = 1'b1;
          try_wa = pos_q[IdxW-1:0];
          try_wd = c_q + 2'd1;
          if (pos_q + 1'b1 < m_q) begin
            try_we2 = 1'b1;
            try_wa2 = IdxW'(pos_q + 1'b1);
          end
          pos_d   = pos_q + 1'b1;
          state_d = S_SRCH_FETCH;
        end else if (blocked) begin
          c_d     = c_q + 2'd1;
          state_d = S_SRCH_TRY;
        end else begin
          nb_d = nb_q & (nb_q - 32'd1);
        end
      end
      S_DONE_OK, S_DONE_FAIL: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rsp_o.done       = (state_q == S_DONE_OK) || (state_q == S_DONE_FAIL);
  assign rsp_o.colourable = (state_q == S_DONE_OK);

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    i_q   <= i_d;
    j_q   <= j_d;
    key_q <= key_d;
    pos_q <= pos_d;
    nb_q  <= nb_d;
    c_q   <= c_d;
    cur_q <= cur_d;
  end

  // Per-vertex stores; a clear resets them all, and try_q can take two writes at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxV; k++) begin
        colour_q[k] <= Uncoloured;
        try_q[k]    <= 2'd0;
      end
    end else begin
      if (col_clr) begin
        for (int k = 0; k < MaxV; k++) begin
          colour_q[k] <= Uncoloured;
          try_q[k]    <= 2'd0;
        end
      end
      if (col_we) begin
        colour_q[col_wa] <= col_wd;
      end
      if (try_we) begin
        try_q[try_wa] <= try_wd;
      end
      if (try_we2) begin
        try_q[try_wa2] <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_q[i_q[IdxW-1:0]] <= popcnt[CntW-1:0];
    end
    if (list_we) begin
      order_q[m_q[IdxW-1:0]] <= i_q[IdxW-1:0];
    end
    if (ord_we) begin
      order_q[ord_wa] <= ord_wd;
    end
  end

endmodule

### design/graph_three_colour_criticality.sv
// Top level of the graph three-colour criticality classifier.
// Depends on g3c_pkg, g3c_ram and g3c_search.
//
// Rows are taken one per cycle while busy is low; each accepted row with
// last_row_i set yields exactly one result strobe. A malformed graph answers
// in the cycle right after its last row, and busy is high for that one cycle.
// A well-formed graph keeps busy high for a data-dependent time: up to
// 1 + n + n*(n+1)/2 tests, each a degree pass over the n rows, an insertion
// sort of up to about n*n/2 steps, and a backtracking search that checks one
// neighbour per cycle in a single shared scan unit. The result strobe cannot
// be held off by the receiver.
module graph_three_colour_criticality #(
  parameter int unsigned MaxV = g3c_pkg::MaxVertices
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic [31:0] neighbour_mask_i,
  input  logic        last_row_i,
  output logic        done_o,
  output logic [1:0]  graph_class_o,
  output logic        malformed_o
);
  import g3c_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxV);
  localparam int unsigned CntW = IdxW + 1;

  ctrl_e state_q, state_d;

  logic [5:0]      vcount_q;
  logic [5:0]      rows_q, rows_d;
  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] u_q, u_d;
  logic [CntW-1:0] v_q, v_d;
  logic [31:0]     erow_q, erow_d;
  logic [1:0]      class_q, class_d;
  logic            mal_q, mal_d;
  logic [CntW-1:0] n_w;
  logic            accept;
  logic            well_formed;

  search_req_t     req;
  search_rsp_t     rsp;
  logic [IdxW-1:0] s_raddr;
  logic [IdxW-1:0] raddr;
  logic [31:0]     rdata;

  assign accept = start && !busy;
  assign n_w    = CntW'(vcount_q);
  assign well_formed = (vcount_q != '0) && (vcount_q <= 6'(MaxV)) &&
                       ((rows_q + 6'd1) == vcount_q);

  g3c_ram #(.Width(32), .Depth(MaxV)) u_adj (
    .clk_i  (clk_i),
    .we_i   (accept && rows_q < 6'(MaxV)),
    .waddr_i(rows_q[IdxW-1:0]),
    .wdata_i(neighbour_mask_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  g3c_search #(.MaxV(MaxV)) u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .n_i    (n_w),
    .req_i  (req),
    .rsp_o  (rsp),
    .raddr_o(s_raddr),
    .rdata_i(rdata)
  );

  // The edge scan reads rows itself; the search owns the port otherwise.
  assign raddr = (state_q == C_NEXT || state_q == C_EDGE_SCAN) ? u_q : s_raddr;

  // Request contents follow the test phase.
  always_comb begin
    req.start      = (state_q == C_RUN);
    req.removed    = '0;
    req.edge_valid = 1'b0;
    req.edge_a     = 5'(u_q);
    req.edge_b     = 5'(v_q[IdxW-1:0]);
    if (phase_q == PH_VERTEX) begin
      req.removed[v_q[IdxW-1:0]] = 1'b1;
    end
    if (phase_q == PH_EDGE) begin
      req.edge_valid = 1'b1;
    end
  end

  // Controller next state.
  always_comb begin
    state_d = state_q;
    rows_d  = rows_q;
    phase_d = phase_q;
    u_d     = u_q;
    v_d     = v_q;
    erow_d  = erow_q;
    class_d = class_q;
    mal_d   = mal_q;
    unique case (state_q)
      C_IDLE: begin
        if (accept) begin
          if (rows_q != 6'd63) begin
            rows_d = rows_q + 6'd1;
          end
          if (last_row_i) begin
            rows_d = '0;
            if (well_formed) begin
              phase_d = PH_FULL;
              v_d     = '0;
              state_d = C_RUN;
            end else begin
              class_d = ClassColourable;
              mal_d   = 1'b1;
              state_d = C_REPORT;
            end
          end
        end
      end
      C_RUN: begin
        state_d = C_WAIT;
      end
      C_WAIT: begin
        if (rsp.done) begin
          mal_d = 1'b0;
          unique case (phase_q)
            PH_FULL: begin
              if (rsp.colourable) begin
                class_d = ClassColourable;
                state_d = C_REPORT;
              end else begin
                phase_d = PH_VERTEX;
                v_d     = '0;
                state_d = C_RUN;
              end
            end
            PH_VERTEX: begin
              if (!rsp.colourable) begin
                class_d = ClassNotCrit;
                state_d = C_REPORT;
              end else if (v_q + 1'b1 >= n_w) begin
                phase_d = PH_EDGE;
                u_d     = '0;
                state_d = C_NEXT;
              end else begin
                v_d     = v_q + 1'b1;
                state_d = C_RUN;
              end
            end
            default: begin
              if (rsp.colourable) begin
                class_d = ClassCritEdge;
                state_d = C_REPORT;
              end else begin
                v_d     = v_q + 1'b1;
                state_d = C_EDGE_SCAN;
              end
            end
          endcase
        end
      end
      // Row of u is being read; start its scan at v = u.
      C_NEXT: begin
        v_d     = CntW'(u_q);
        state_d = C_EDGE_SCAN;
        erow_d  = '0;
      end
      // One candidate pair per cycle, until a pair with an edge starts a search.
      C_EDGE_SCAN: begin
        if (erow_q == '0 && v_q == CntW'(u_q)) begin
          erow_d = rdata;
        end
        if (v_q >= n_w) begin
          if (CntW'(u_q) + 1'b1 >= n_w) begin
            class_d = ClassTarget;
            state_d = C_REPORT;
          end else begin
            u_d     = u_q + 1'b1;
            state_d = C_NEXT;
          end
        end else if (((v_q == CntW'(u_q)) ? rdata[v_q[IdxW-1:0]]
                                          : erow_q[v_q[IdxW-1:0]])) begin
          if (v_q == CntW'(u_q)) begin
            erow_d = rdata;
          end
          state_d = C_RUN;
        end else begin
          if (v_q == CntW'(u_q)) begin
            erow_d = rdata;
          end
          v_d = v_q + 1'b1;
        end
      end
      C_REPORT: begin
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    busy          = (state_q != C_IDLE);
    done_o        = (state_q == C_REPORT);
    graph_class_o = class_q;
    malformed_o   = mal_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= C_IDLE;
      rows_q   <= '0;
      vcount_q <= VertexCountRst;
      phase_q  <= PH_FULL;
    end else begin
      state_q <= state_d;
      rows_q  <= rows_d;
      phase_q <= phase_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    u_q     <= u_d;
    v_q     <= v_d;
    erow_q  <= erow_d;
    class_q <= class_d;
    mal_q   <= mal_d;
  end

endmodule
